// File: hw/rtl/aypb_pkg.sv
// Shared types and constants of the palette overlay blend block.
package aypb_pkg;

  localparam int ByteW    = 8;
  localparam int EntryW   = 32;
  localparam int CfgDataW = 64;
  localparam int CfgIdxW  = 4;
  localparam int PalPairs = 8;
  localparam int PalAddrW = $clog2(PalPairs);

  // Queue between front and back, and result queue in the back.
  localparam int MidDepth = 4;
  localparam int MidPtrW  = $clog2(MidDepth);
  localparam int MidCntW  = $clog2(MidDepth + 1);
  localparam int OutDepth = 8;
  localparam int OutPtrW  = $clog2(OutDepth);
  localparam int OutCntW  = $clog2(OutDepth + 1);

  // YUV to RGB coefficients, 12 fractional bits.
  localparam int CoefRv   = 5743;
  localparam int CoefGu   = 1411;
  localparam int CoefGv   = 2925;
  localparam int CoefBu   = 7258;
  localparam int FracBits = 12;
  localparam int ChanMax  = 255;
  localparam int ChromaMax = 127;

  // One classified word: combined palette colour and the background pixel.
  typedef struct packed {
    logic [ByteW-1:0] a;
    logic [ByteW-1:0] y;
    logic [ByteW-1:0] u;
    logic [ByteW-1:0] v;
    logic [ByteW-1:0] bg_r;
    logic [ByteW-1:0] bg_g;
    logic [ByteW-1:0] bg_b;
  } op_t;

  typedef struct packed {
    logic [ByteW-1:0] r;
    logic [ByteW-1:0] g;
    logic [ByteW-1:0] b;
  } rgb_t;

endpackage

// File: hw/rtl/ayuv_palette_pixel_blend.sv
// Top level of the palette overlay blend: front, queue and back part.
//
//  Channel   Direction  Handshake            Payload
//  input     in         push / full          pixel_i, bg_red_i, bg_green_i, bg_blue_i
//  result    out        empty / pop          out_red_o, out_green_o, out_blue_o
//  config    in         cfg_we_i             cfg_idx_i, cfg_data_i
//
// One word is accepted per clock cycle while pop keeps up; each word then
// passes the palette RAM read, the middle queue and three arithmetic stages
// in the back part before its result is queued.
// Reset clears the palette to zero at once through a valid bit per pair.
// A stalled result side fills the eight-word result queue and the four-word
// middle queue before full rises.
module ayuv_palette_pixel_blend (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [aypb_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [aypb_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          push,
  output logic                          full,
  input  logic [aypb_pkg::ByteW-1:0]    pixel_i,
  input  logic [aypb_pkg::ByteW-1:0]    bg_red_i,
  input  logic [aypb_pkg::ByteW-1:0]    bg_green_i,
  input  logic [aypb_pkg::ByteW-1:0]    bg_blue_i,
  output logic                          empty,
  input  logic                          pop,
  output logic [aypb_pkg::ByteW-1:0]    out_red_o,
  output logic [aypb_pkg::ByteW-1:0]    out_green_o,
  output logic [aypb_pkg::ByteW-1:0]    out_blue_o
);
  import aypb_pkg::*;

  logic mid_push, mid_full, mid_pop, mid_empty;
  op_t  mid_in, mid_out;

  aypb_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .push_i    (push),
    .full_o    (full),
    .pixel_i   (pixel_i),
    .bg_red_i  (bg_red_i),
    .bg_green_i(bg_green_i),
    .bg_blue_i (bg_blue_i),
    .q_full_i  (mid_full),
    .q_push_o  (mid_push),
    .q_data_o  (mid_in)
  );

  aypb_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (mid_push),
    .data_i (mid_in),
    .full_o (mid_full),
    .pop_i  (mid_pop),
    .empty_o(mid_empty),
    .data_o (mid_out)
  );

  aypb_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (mid_empty),
    .q_data_i   (mid_out),
    .q_pop_o    (mid_pop),
    .pop_i      (pop),
    .empty_o    (empty),
    .out_red_o  (out_red_o),
    .out_green_o(out_green_o),
    .out_blue_o (out_blue_o)
  );

endmodule

// File: hw/rtl/aypb_ram.sv
// Generic RAM with one write port and two registered read ports.
module aypb_ram #(
  parameter int Width = 32,
  parameter int Depth = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_a_o,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_a_q;
  logic [Width-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// File: hw/rtl/aypb_front.sv
// Front part: palette RAM, lookup of both entries and colour combining.
module aypb_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [aypb_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [aypb_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                           push_i,
  output logic                           full_o,
  input  logic [aypb_pkg::ByteW-1:0]     pixel_i,
  input  logic [aypb_pkg::ByteW-1:0]     bg_red_i,
  input  logic [aypb_pkg::ByteW-1:0]     bg_green_i,
  input  logic [aypb_pkg::ByteW-1:0]     bg_blue_i,
  input  logic                           q_full_i,
  output logic                           q_push_o,
  output aypb_pkg::op_t                  q_data_o
);
  import aypb_pkg::*;

  localparam logic signed [ByteW:0] ChromaHi = (ByteW+1)'(ChromaMax);
  localparam logic signed [ByteW:0] ChromaLo = -ChromaHi;

  function automatic logic [ByteW-1:0] clamp_chroma(input logic signed [ByteW:0] s);
    logic [ByteW-1:0] r;
    if (s > ChromaHi) begin
      r = ChromaHi[ByteW-1:0];
    end else if (s < ChromaLo) begin
      r = ChromaLo[ByteW-1:0];
    end else begin
      r = s[ByteW-1:0];
    end
    return r;
  endfunction

  logic                 accept;
  logic                 pal_we;
  logic [PalPairs-1:0]  pal_vld_q, pal_vld_d;
  logic [PalAddrW-1:0]  addr_a, addr_b;
  logic [CfgDataW-1:0]  rdata_a, rdata_b;

  logic                 f_vld_q, f_vld_d;
  logic                 hi_a_q, hi_b_q;
  logic                 ent_vld_a_q, ent_vld_b_q;
  logic [ByteW-1:0]     bg_r_q, bg_g_q, bg_b_q;

  logic [EntryW-1:0]    e1, e2;
  logic [ByteW:0]       a_sum, y_sum;
  logic signed [ByteW:0] u_sum, v_sum;

  assign full_o   = f_vld_q && q_full_i;
  assign accept   = push_i && !full_o;
  assign q_push_o = f_vld_q && !q_full_i;

  // Writes beyond the last palette pair are dropped.
  assign pal_we = cfg_we_i && (cfg_idx_i < CfgIdxW'(PalPairs));
  assign addr_a = pixel_i[PalAddrW:1];
  assign addr_b = pixel_i[ByteW-1:ByteW-PalAddrW];

  aypb_ram #(
    .Width(CfgDataW),
    .Depth(PalPairs)
  ) u_pal_ram (
    .clk_i    (clk_i),
    .we_i     (pal_we),
    .waddr_i  (cfg_idx_i[PalAddrW-1:0]),
    .wdata_i  (cfg_data_i),
    .re_i     (accept),
    .raddr_a_i(addr_a),
    .raddr_b_i(addr_b),
    .rdata_a_o(rdata_a),
    .rdata_b_o(rdata_b)
  );

  // A pair never written since reset reads as zero.
  always_comb begin
    pal_vld_d = pal_vld_q;
    if (pal_we) begin
      pal_vld_d[cfg_idx_i[PalAddrW-1:0]] = 1'b1;
    end
  end

  always_comb begin
    f_vld_d = f_vld_q;
    if (accept) begin
      f_vld_d = 1'b1;
    end else if (q_push_o) begin
      f_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pal_vld_q <= '0;
      f_vld_q   <= 1'b0;
    end else begin
      pal_vld_q <= pal_vld_d;
      f_vld_q   <= f_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      hi_a_q      <= pixel_i[0];
      hi_b_q      <= pixel_i[ByteW-PalAddrW-1];
      ent_vld_a_q <= pal_vld_q[addr_a];
      ent_vld_b_q <= pal_vld_q[addr_b];
      bg_r_q      <= bg_red_i;
      bg_g_q      <= bg_green_i;
      bg_b_q      <= bg_blue_i;
    end
  end

  always_comb begin
    e1 = hi_a_q ? rdata_a[CfgDataW-1:EntryW] : rdata_a[EntryW-1:0];
    e2 = hi_b_q ? rdata_b[CfgDataW-1:EntryW] : rdata_b[EntryW-1:0];
    if (!ent_vld_a_q) begin
      e1 = '0;
    end
    if (!ent_vld_b_q) begin
      e2 = '0;
    end

    a_sum = {1'b0, e1[7:0]} + {1'b0, e2[7:0]};
    y_sum = {1'b0, e1[15:8]} + {1'b0, e2[15:8]};
    u_sum = $signed({e1[23], e1[23:16]}) + $signed({e2[23], e2[23:16]});
    v_sum = $signed({e1[31], e1[31:24]}) + $signed({e2[31], e2[31:24]});

    q_data_o.a    = a_sum[ByteW:1];
    q_data_o.y    = y_sum[ByteW] ? ByteW'(ChanMax) : y_sum[ByteW-1:0];
    q_data_o.u    = clamp_chroma(u_sum);
    q_data_o.v    = clamp_chroma(v_sum);
    q_data_o.bg_r = bg_r_q;
    q_data_o.bg_g = bg_g_q;
    q_data_o.bg_b = bg_b_q;
  end

endmodule

// File: hw/rtl/aypb_queue.sv
// Short queue of classified words between the front and the back part.
module aypb_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  aypb_pkg::op_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output aypb_pkg::op_t data_o
);
  import aypb_pkg::*;

  op_t                mem_q [MidDepth];
  logic [MidPtrW-1:0] wptr_q, wptr_d;
  logic [MidPtrW-1:0] rptr_q, rptr_d;
  logic [MidCntW-1:0] cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == MidCntW'(MidDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = do_push ? wptr_q + MidPtrW'(1) : wptr_q;
    rptr_d = do_pop ? rptr_q + MidPtrW'(1) : rptr_q;
    cnt_d  = cnt_q + MidCntW'(do_push) - MidCntW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

// File: hw/rtl/aypb_back.sv
// Back part: YUV to RGB conversion, alpha blend, divide by 255, result queue.
module aypb_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       q_empty_i,
  input  aypb_pkg::op_t              q_data_i,
  output logic                       q_pop_o,
  input  logic                       pop_i,
  output logic                       empty_o,
  output logic [aypb_pkg::ByteW-1:0] out_red_o,
  output logic [aypb_pkg::ByteW-1:0] out_green_o,
  output logic [aypb_pkg::ByteW-1:0] out_blue_o
);
  import aypb_pkg::*;

  localparam int ProdW = 22;
  localparam int SumW  = 23;
  localparam int BaseW = ByteW + FracBits;
  localparam int MixW  = 2 * ByteW;

  localparam logic signed [ProdW-1:0] KRv = ProdW'(CoefRv);
  localparam logic signed [ProdW-1:0] KGu = ProdW'(CoefGu);
  localparam logic signed [ProdW-1:0] KGv = ProdW'(CoefGv);
  localparam logic signed [ProdW-1:0] KBu = ProdW'(CoefBu);

  // Floor shift by the fraction, then clip to a byte.
  function automatic logic [ByteW-1:0] fix_to_byte(input logic signed [SumW-1:0] t);
    logic [ByteW-1:0] r;
    if (t[SumW-1]) begin
      r = '0;
    end else if (|t[SumW-2:FracBits+ByteW]) begin
      r = ByteW'(ChanMax);
    end else begin
      r = t[FracBits+ByteW-1:FracBits];
    end
    return r;
  endfunction

  // Exact x / 255 for x up to 255 * 255.
  function automatic logic [ByteW-1:0] div255(input logic [MixW-1:0] x);
    logic [MixW:0] t;
    t = {1'b0, x} + {{(ByteW+1){1'b0}}, x[MixW-1:ByteW]} + (MixW+1)'(1);
    return t[MixW-1:ByteW];
  endfunction

  function automatic logic [MixW-1:0] mix(input logic [ByteW-1:0] c,
                                          input logic [ByteW-1:0] bg,
                                          input logic [ByteW-1:0] a);
    logic [MixW-1:0] p_fg, p_bg;
    p_fg = {{ByteW{1'b0}}, c} * {{ByteW{1'b0}}, a};
    p_bg = {{ByteW{1'b0}}, bg} * {{ByteW{1'b0}}, ~a};
    return p_fg + p_bg;
  endfunction

  logic                 issue;
  logic                 out_pop;
  logic                 out_empty;
  logic [OutCntW-1:0]   reserved_q, reserved_d;

  logic signed [ProdW-1:0] u_ext, v_ext;

  // Stage 1: chroma products.
  logic                    s1_vld_q;
  logic signed [ProdW-1:0] s1_pr_q, s1_pgu_q, s1_pgv_q, s1_pb_q;
  logic [BaseW-1:0]        s1_base_q;
  logic [ByteW-1:0]        s1_a_q;
  rgb_t                    s1_bg_q;

  // Stage 2: converted colour.
  logic                    s2_vld_q;
  logic signed [SumW-1:0]  base_ext, t_r, t_g, t_b;
  rgb_t                    s2_c_q;
  logic [ByteW-1:0]        s2_a_q;
  rgb_t                    s2_bg_q;

  // Stage 3: blended sums before the divide.
  logic                    s3_vld_q;
  logic [MixW-1:0]         s3_mr_q, s3_mg_q, s3_mb_q;

  rgb_t                    out_mem_q [OutDepth];
  rgb_t                    out_word;
  rgb_t                    out_head;
  logic [OutPtrW-1:0]      out_wptr_q, out_rptr_q;
  logic [OutCntW-1:0]      out_cnt_q, out_cnt_d;

  // A word is only issued when the result queue has a place reserved for it,
  // so the stages never have to stall.
  assign issue   = !q_empty_i && (reserved_q < OutCntW'(OutDepth));
  assign q_pop_o = issue;

  assign out_empty = (out_cnt_q == '0);
  assign out_pop   = pop_i && !out_empty;
  assign empty_o   = out_empty;

  always_comb begin
    reserved_d = reserved_q + OutCntW'(issue) - OutCntW'(out_pop);
    out_cnt_d  = out_cnt_q + OutCntW'(s3_vld_q) - OutCntW'(out_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reserved_q <= '0;
      s1_vld_q   <= 1'b0;
      s2_vld_q   <= 1'b0;
      s3_vld_q   <= 1'b0;
      out_wptr_q <= '0;
      out_rptr_q <= '0;
      out_cnt_q  <= '0;
    end else begin
      reserved_q <= reserved_d;
      s1_vld_q   <= issue;
      s2_vld_q   <= s1_vld_q;
      s3_vld_q   <= s2_vld_q;
      out_cnt_q  <= out_cnt_d;
      if (s3_vld_q) begin
        out_wptr_q <= out_wptr_q + OutPtrW'(1);
      end
      if (out_pop) begin
        out_rptr_q <= out_rptr_q + OutPtrW'(1);
      end
    end
  end

  assign u_ext = ProdW'($signed(q_data_i.u));
  assign v_ext = ProdW'($signed(q_data_i.v));

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_pr_q   <= v_ext * KRv;
      s1_pgu_q  <= u_ext * KGu;
      s1_pgv_q  <= v_ext * KGv;
      s1_pb_q   <= u_ext * KBu;
      // Y scaled by the fraction plus the rounding half.
      s1_base_q <= {q_data_i.y, 1'b1, (FracBits-1)'(0)};
      s1_a_q    <= q_data_i.a;
      s1_bg_q   <= '{r: q_data_i.bg_r, g: q_data_i.bg_g, b: q_data_i.bg_b};
    end
  end

  always_comb begin
    base_ext = $signed({(SumW-BaseW)'(0), s1_base_q});
    t_r = base_ext + SumW'(s1_pr_q);
    t_g = base_ext - SumW'(s1_pgu_q) - SumW'(s1_pgv_q);
    t_b = base_ext + SumW'(s1_pb_q);
  end

  always_ff @(posedge clk_i) begin
    if (s1_vld_q) begin
      s2_c_q  <= '{r: fix_to_byte(t_r), g: fix_to_byte(t_g), b: fix_to_byte(t_b)};
      s2_a_q  <= s1_a_q;
      s2_bg_q <= s1_bg_q;
    end
    if (s2_vld_q) begin
      s3_mr_q <= mix(s2_c_q.r, s2_bg_q.r, s2_a_q);
      s3_mg_q <= mix(s2_c_q.g, s2_bg_q.g, s2_a_q);
      s3_mb_q <= mix(s2_c_q.b, s2_bg_q.b, s2_a_q);
    end
  end

  assign out_word = '{r: div255(s3_mr_q), g: div255(s3_mg_q), b: div255(s3_mb_q)};

  always_ff @(posedge clk_i) begin
    if (s3_vld_q) begin
      out_mem_q[out_wptr_q] <= out_word;
    end
  end

  assign out_head    = out_mem_q[out_rptr_q];
  assign out_red_o   = out_head.r;
  assign out_green_o = out_head.g;
  assign out_blue_o  = out_head.b;

  // Reservations cover both the words in flight and those already queued.
  a_reserved_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    reserved_q <= OutCntW'(OutDepth))
    else $error("result queue over-reserved");

  a_queued_within_reserved : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_cnt_q <= reserved_q)
    else $error("result queue holds more words than were reserved");

  a_no_write_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_vld_q |-> (out_cnt_q < OutCntW'(OutDepth)))
    else $error("result written into a full queue");

  a_issue_reaches_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue |=> ##2 s3_vld_q)
    else $error("issued word lost in the pipeline");

endmodule
